### src/aes128_pkg.sv
// Shared types, constants and byte functions for the AES-128 encrypt core.
// No dependencies; imported by aes128_round and aes128_block_encrypt_core.
`default_nettype none

package aes128_pkg;

    // Byte 0 sits in element 0, the most significant byte of the vector
    typedef logic [0:15][7:0] block_t;

    // Per-stage round settings, fixed at elaboration
    typedef struct packed {
        logic [7:0] rcon;
        logic       last;
    } round_cfg_t;

    localparam int unsigned NUM_ROUNDS = 10;
    localparam int unsigned PIPE_DEPTH = NUM_ROUNDS + 1;
    localparam int unsigned CNT_W      = $clog2(PIPE_DEPTH + 1);

    localparam logic [7:0] GF_POLY = 8'h1B;

    // Round constants for key expansion, rounds 1 to 10
    localparam logic [7:0] RCON_TAB [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

    localparam logic [7:0] SBOX_TAB [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX_TAB[b];
    endfunction

    // Multiply by x in GF(2^8), polynomial 0x11B
    function automatic logic [7:0] gf_dbl(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
    endfunction

endpackage

`default_nettype wire

### src/aes128_round.sv
// One AES-128 round as a pipeline stage: SubBytes, ShiftRows, optional
// MixColumns, on-the-fly key expansion and AddRoundKey. Uses aes128_pkg.
`default_nettype none

module aes128_round (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  aes128_pkg::round_cfg_t  cfg,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  aes128_pkg::block_t      in_state,
    input  aes128_pkg::block_t      in_key,
    output logic                    out_valid,
    input  wire                     out_ready,
    output aes128_pkg::block_t      out_state,
    output aes128_pkg::block_t      out_key
);
    import aes128_pkg::*;

    logic   valid_reg, valid_next;
    block_t state_reg, state_next;
    block_t key_reg, key_next;
    block_t shifted;
    block_t mixed;
    logic [7:0] t0, t1, t2, t3;

    // SubBytes and ShiftRows, byte index = row + 4 * column
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                shifted[r + 4 * c] = sbox(in_state[r + 4 * ((c + r) % 4)]);
            end
        end
    end

    // MixColumns, bypassed in the final round
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
            a0 = shifted[4 * c];
            a1 = shifted[4 * c + 1];
            a2 = shifted[4 * c + 2];
            a3 = shifted[4 * c + 3];
            d0 = gf_dbl(a0);
            d1 = gf_dbl(a1);
            d2 = gf_dbl(a2);
            d3 = gf_dbl(a3);
            if (cfg.last) begin
                mixed[4 * c]     = a0;
                mixed[4 * c + 1] = a1;
                mixed[4 * c + 2] = a2;
                mixed[4 * c + 3] = a3;
            end else begin
                mixed[4 * c]     = d0 ^ d1 ^ a1 ^ a2 ^ a3;
                mixed[4 * c + 1] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
                mixed[4 * c + 2] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
                mixed[4 * c + 3] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
            end
        end
    end

    // Key expansion: RotWord, SubWord, Rcon, then the word chain
    assign t0 = sbox(in_key[13]) ^ cfg.rcon;
    assign t1 = sbox(in_key[14]);
    assign t2 = sbox(in_key[15]);
    assign t3 = sbox(in_key[12]);

    always_comb begin
        key_next[0] = in_key[0] ^ t0;
        key_next[1] = in_key[1] ^ t1;
        key_next[2] = in_key[2] ^ t2;
        key_next[3] = in_key[3] ^ t3;
        for (int w = 1; w < 4; w++) begin
            for (int j = 0; j < 4; j++) begin
                key_next[4 * w + j] = in_key[4 * w + j] ^ key_next[4 * (w - 1) + j];
            end
        end
    end

    assign state_next = mixed ^ key_next;

    // Stage handshake: load whenever empty or the next stage takes the word
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            state_reg <= state_next;
            key_reg   <= key_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_key   = key_reg;

endmodule

`default_nettype wire

### src/aes128_block_encrypt_core.sv
// AES-128 encrypt core: input key-add stage followed by ten round stages.
// Uses aes128_pkg and aes128_round.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_      | in  | s_valid / s_ready  | s_key_high, s_key_low, s_block_high/low
//  m_      | out | m_valid / m_ready  | m_cipher_high, m_cipher_low
//
//  m_valid rises once the word has passed the key-add register, which loads
//  on the accepting edge, and then the ten round-stage registers, each
//  round stage holding one SBOX-and-XOR level of logic.
//  One word is accepted per cycle while m_ready stays high.
//  Reset (aresetn, synchronous, active low) clears every stage valid bit.
//  On a stall each stage holds its word; an empty stage still takes a new
//  word, so bubbles close up and nothing is lost or repeated.
`default_nettype none

module aes128_block_encrypt_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [63:0] s_key_high,
    input  wire  [63:0] s_key_low,
    input  wire  [63:0] s_block_high,
    input  wire  [63:0] s_block_low,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [63:0] m_cipher_high,
    output logic [63:0] m_cipher_low
);
    import aes128_pkg::*;

    block_t                  state_bus [NUM_ROUNDS + 1];
    block_t                  key_bus   [NUM_ROUNDS + 1];
    logic [NUM_ROUNDS:0]     valid_vec;
    logic [NUM_ROUNDS:0]     ready_vec;

    logic   load_valid_reg, load_valid_next;
    block_t load_state_reg;
    block_t load_key_reg;
    block_t in_key;
    block_t in_block;

    logic             in_acc, out_acc;
    logic [CNT_W-1:0] inflight_reg, inflight_next;

    // Initial round-key add
    assign in_key   = {s_key_high, s_key_low};
    assign in_block = {s_block_high, s_block_low};

    assign s_ready         = !load_valid_reg || ready_vec[0];
    assign load_valid_next = s_ready ? s_valid : load_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_valid_reg <= 1'b0;
        end else begin
            load_valid_reg <= load_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            load_state_reg <= in_block ^ in_key;
            load_key_reg   <= in_key;
        end
    end

    assign valid_vec[0] = load_valid_reg;
    assign state_bus[0] = load_state_reg;
    assign key_bus[0]   = load_key_reg;

    // Round stages 1 to 10
    for (genvar i = 1; i <= NUM_ROUNDS; i++) begin : g_round
        round_cfg_t round_cfg;

        assign round_cfg.rcon = RCON_TAB[i - 1];
        assign round_cfg.last = (i == NUM_ROUNDS);

        aes128_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cfg       (round_cfg),
            .in_valid  (valid_vec[i - 1]),
            .in_ready  (ready_vec[i - 1]),
            .in_state  (state_bus[i - 1]),
            .in_key    (key_bus[i - 1]),
            .out_valid (valid_vec[i]),
            .out_ready (ready_vec[i]),
            .out_state (state_bus[i]),
            .out_key   (key_bus[i])
        );
    end

    assign ready_vec[NUM_ROUNDS] = m_ready;
    assign m_valid       = valid_vec[NUM_ROUNDS];
    assign m_cipher_high = state_bus[NUM_ROUNDS][0:7];
    assign m_cipher_low  = state_bus[NUM_ROUNDS][8:15];

    // Words in flight, tracked for checking the stage valid bits
    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        unique case ({in_acc, out_acc})
            2'b10:   inflight_next = inflight_reg + CNT_W'(1);
            2'b01:   inflight_next = inflight_reg - CNT_W'(1);
            default: inflight_next = inflight_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    // Every word in flight occupies exactly one stage
    a_inflight_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg == CNT_W'($countones(valid_vec)))
        else $error("stage valid bits disagree with words in flight");

    // An empty or draining output means the whole pipe can advance
    a_ready_when_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input stalled while output is free");

    // Reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && valid_vec == '0))
        else $error("pipe not empty after reset");

    // Pipe never holds more words than stages
    a_inflight_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg <= CNT_W'(PIPE_DEPTH))
        else $error("words in flight exceed pipe depth");

endmodule

`default_nettype wire
